/* rtl/core/lp_pkg.sv */
// shared constants and types for the legendre value and slope core
`default_nettype none
package lp_pkg;
    localparam int MAX_DEGREE_DEF = 32;
    localparam int FRAC_BITS = 30;
    localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRAC_BITS);

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DEG = 2'd1;
    localparam logic [1:0] STAT_PT  = 2'd2;

    typedef struct packed {
        logic               vld;
        logic [5:0]         deg;
        logic signed [31:0] x;
        logic signed [31:0] pp;
        logic signed [31:0] pc;
    } t_cell_bus;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_CHAIN,
        TOP_SLOPE,
        TOP_FIN
    } t_top_state;

    typedef enum logic [2:0] {
        SLP_IDLE,
        SLP_MUL,
        SLP_PREP,
        SLP_CHECK,
        SLP_DIV,
        SLP_ROUND,
        SLP_FIN
    } t_slp_state;
endpackage
`default_nettype wire

/* rtl/core/legendre_poly_value_and_slope_core.sv */
// Legendre P_n(x) and dP_n/dx in Q30: one item at a time. A valid item runs through a
// row of MAX_DEGREE-1 pipelined recurrence cells, then through the slope unit and its
// bit-serial division. Items with a bad degree or point finish with zero value and slope.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module legendre_poly_value_and_slope_core #(
    parameter int MAX_DEGREE = lp_pkg::MAX_DEGREE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [5:0]         i_degree,
    input  wire logic signed [31:0] i_point,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_value,
    output logic signed [40:0]      o_slope,
    output logic [1:0]              o_status
);
    lp_pkg::t_top_state r_state, n_state;
    lp_pkg::t_cell_bus  w_bus [1:MAX_DEGREE];
    logic               w_accept, w_deg_bad, w_pt_bad, w_slp_done, w_fin_load;
    logic signed [40:0] w_slp_slope;
    logic signed [31:0] r_p1, r_oval;
    logic signed [40:0] r_slope, r_oslope;
    logic [1:0]         r_status, r_ostat;
    logic               r_ovld;

    assign o_ready   = (r_state == lp_pkg::TOP_IDLE);
    assign w_accept  = i_valid & o_ready;
    assign w_deg_bad = (i_degree == 6'd0) || ({1'b0, i_degree} > 7'(MAX_DEGREE));
    assign w_pt_bad  = (i_point > lp_pkg::ONE_Q) || (i_point < -lp_pkg::ONE_Q);

    always_comb begin
        w_bus[1].vld = w_accept & ~w_deg_bad & ~w_pt_bad;
        w_bus[1].deg = i_degree;
        w_bus[1].x   = i_point;
        w_bus[1].pp  = lp_pkg::ONE_Q;
        w_bus[1].pc  = i_point;
    end

    for (genvar k = 2; k <= MAX_DEGREE; k++) begin : g_cell
        lp_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[k-1]),
            .o_bus   (w_bus[k])
        );
    end

    lp_slope u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bus[MAX_DEGREE].vld),
        .i_deg   (w_bus[MAX_DEGREE].deg),
        .i_x     (w_bus[MAX_DEGREE].x),
        .i_p0    (w_bus[MAX_DEGREE].pp),
        .i_p1    (w_bus[MAX_DEGREE].pc),
        .o_done  (w_slp_done),
        .o_slope (w_slp_slope)
    );

    assign w_fin_load = (r_state == lp_pkg::TOP_FIN) && (!r_ovld || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lp_pkg::TOP_IDLE: begin
                if (w_accept) begin
                    n_state = (w_deg_bad || w_pt_bad) ? lp_pkg::TOP_FIN : lp_pkg::TOP_CHAIN;
                end
            end
            lp_pkg::TOP_CHAIN: if (w_bus[MAX_DEGREE].vld) n_state = lp_pkg::TOP_SLOPE;
            lp_pkg::TOP_SLOPE: if (w_slp_done) n_state = lp_pkg::TOP_FIN;
            lp_pkg::TOP_FIN:   if (w_fin_load) n_state = lp_pkg::TOP_IDLE;
            default:           n_state = lp_pkg::TOP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lp_pkg::TOP_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_load) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1     <= '0;
            r_slope  <= '0;
            r_status <= w_deg_bad ? lp_pkg::STAT_DEG : lp_pkg::STAT_PT;
        end
        if (r_state == lp_pkg::TOP_CHAIN && w_bus[MAX_DEGREE].vld) begin
            r_p1 <= w_bus[MAX_DEGREE].pc;
        end
        if (r_state == lp_pkg::TOP_SLOPE && w_slp_done) begin
            r_slope  <= w_slp_slope;
            r_status <= lp_pkg::STAT_OK;
        end
        if (w_fin_load) begin
            r_oval   <= r_p1;
            r_oslope <= r_slope;
            r_ostat  <= r_status;
        end
    end

    assign o_valid  = r_ovld;
    assign o_value  = r_oval;
    assign o_slope  = r_oslope;
    assign o_status = r_ostat;

    a_chain_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bus[MAX_DEGREE].vld |-> r_state == lp_pkg::TOP_CHAIN)
        else $error("cell row finished outside chain state");
    a_slope_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slp_done |-> r_state == lp_pkg::TOP_SLOPE)
        else $error("slope unit finished outside slope state");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_ostat != lp_pkg::STAT_OK) |-> (r_oval == '0 && r_oslope == '0))
        else $error("error result with nonzero payload");
endmodule
`default_nettype wire

/* rtl/core/lp_cell.sv */
// recurrence cell, five stages: P_IDX from P_(IDX-1), P_(IDX-2) if IDX <= deg
`default_nettype none
module lp_cell #(
    parameter int IDX = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lp_pkg::t_cell_bus i_bus,
    output lp_pkg::t_cell_bus      o_bus
);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / IDX);
    localparam logic signed [39:0] IDX_S = 40'(IDX);
    localparam logic signed [39:0] HALF_S = 40'(IDX / 2);
    localparam logic [61:0] RND = 62'(1) << (lp_pkg::FRAC_BITS - 1);
    localparam logic signed [39:0] ONE_S = 40'(lp_pkg::ONE_Q);

    lp_pkg::t_cell_bus r_b1, r_b2, r_b3, r_b4, r_b5;
    logic [61:0]        r1_prod;
    logic               r1_neg;
    logic signed [39:0] r2_a, r2_b, r3_a, r4_a;
    logic [31:0]        r3_u, r4_u;
    logic               r3_nneg, r3_xneg, r4_nneg, r4_xneg;
    logic [63:0]        r4_prod;

    logic [30:0]        n_ax, n_apc;
    logic [32:0]        n_m;
    logic signed [39:0] n_t, n_num, n_xv, n_uw;
    logic signed [39:0] n_q0, n_rem, n_d, n_f, n_q, n_qc;
    lp_pkg::t_cell_bus  n_b5;

    always_comb begin
        n_ax  = 31'(i_bus.x[31] ? -i_bus.x : i_bus.x);
        n_apc = 31'(i_bus.pc[31] ? -i_bus.pc : i_bus.pc);
        // round product to nearest, ties away from zero
        n_m = 33'((r1_prod + RND) >> lp_pkg::FRAC_BITS);
        n_t = r1_neg ? -$signed({7'd0, n_m}) : $signed({7'd0, n_m});
        // num = IDX*A + B where A = 2t - pp and B = pp - t
        n_num = IDX_S * r2_a + r2_b;
        n_xv  = n_num[39] ? HALF_S - r2_b : r2_b + HALF_S;
        n_uw  = n_xv[39] ? IDX_S - 40'sd1 - n_xv : n_xv;
        // reciprocal quotient is low by at most one
        n_q0  = $signed({8'd0, r4_prod[63:32]});
        n_rem = $signed({8'd0, r4_u}) - n_q0 * IDX_S;
        n_d   = (n_rem >= IDX_S) ? n_q0 + 40'sd1 : n_q0;
        n_f   = r4_xneg ? -n_d : n_d;
        n_q   = r4_nneg ? r4_a - n_f : r4_a + n_f;
        if (n_q > ONE_S) begin
            n_qc = ONE_S;
        end else if (n_q < -ONE_S) begin
            n_qc = -ONE_S;
        end else begin
            n_qc = n_q;
        end
        n_b5 = r_b4;
        if (7'(IDX) <= {1'b0, r_b4.deg}) begin
            n_b5.pp = r_b4.pc;
            n_b5.pc = 32'(n_qc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1.vld <= 1'b0;
            r_b2.vld <= 1'b0;
            r_b3.vld <= 1'b0;
            r_b4.vld <= 1'b0;
            r_b5.vld <= 1'b0;
        end else begin
            r_b1.vld <= i_bus.vld;
            r_b2.vld <= r_b1.vld;
            r_b3.vld <= r_b2.vld;
            r_b4.vld <= r_b3.vld;
            r_b5.vld <= n_b5.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        {r_b1.deg, r_b1.x, r_b1.pp, r_b1.pc} <= {i_bus.deg, i_bus.x, i_bus.pp, i_bus.pc};
        {r_b2.deg, r_b2.x, r_b2.pp, r_b2.pc} <= {r_b1.deg, r_b1.x, r_b1.pp, r_b1.pc};
        {r_b3.deg, r_b3.x, r_b3.pp, r_b3.pc} <= {r_b2.deg, r_b2.x, r_b2.pp, r_b2.pc};
        {r_b4.deg, r_b4.x, r_b4.pp, r_b4.pc} <= {r_b3.deg, r_b3.x, r_b3.pp, r_b3.pc};
        {r_b5.deg, r_b5.x, r_b5.pp, r_b5.pc} <= {n_b5.deg, n_b5.x, n_b5.pp, n_b5.pc};
        r1_prod <= 62'(n_ax) * 62'(n_apc);
        r1_neg  <= i_bus.x[31] ^ i_bus.pc[31];
        r2_a    <= (n_t <<< 1) - 40'(r_b1.pp);
        r2_b    <= 40'(r_b1.pp) - n_t;
        r3_a    <= r2_a;
        r3_u    <= 32'(n_uw);
        r3_nneg <= n_num[39];
        r3_xneg <= n_xv[39];
        r4_prod <= 64'(r3_u) * 64'(RECIP);
        r4_u    <= r3_u;
        r4_a    <= r3_a;
        r4_nneg <= r3_nneg;
        r4_xneg <= r3_xneg;
    end

    assign o_bus = r_b5;
endmodule
`default_nettype wire

/* rtl/core/lp_slope.sv */
// slope unit: closed form at the ends, bit-serial restoring division elsewhere unless the result is zero or saturates
`default_nettype none
module lp_slope (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [5:0]         i_deg,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_p0,
    input  wire logic signed [31:0] i_p1,
    output logic                    o_done,
    output logic signed [40:0]      o_slope
);
    localparam logic [61:0] RND = 62'(1) << (lp_pkg::FRAC_BITS - 1);
    localparam int QBITS = 41;
    localparam logic [5:0] LAST = 6'(QBITS - 1);
    localparam int SHIFT0 = 2 * lp_pkg::FRAC_BITS - QBITS;

    lp_pkg::t_slp_state r_state, n_state;
    logic [5:0]         r_n, r_cnt;
    logic signed [31:0] r_x, r_p0, r_p1;
    logic [61:0]        r_prod;
    logic               r_pneg, r_dneg, r_sneg;
    logic [31:0]        r_fa, r_fb;
    logic [37:0]        r_amag;
    logic [60:0]        r_den, r_rem;
    logic [40:0]        r_q, r_lim;

    logic [32:0]        n_m;
    logic signed [39:0] n_t, n_d, n_ad;
    logic [61:0]        n_rem2, n_rem0;
    logic [10:0]        n_tri;
    logic [41:0]        n_qr;
    logic               n_closed;

    always_comb begin
        n_m      = 33'((r_prod + RND) >> lp_pkg::FRAC_BITS);
        n_t      = r_pneg ? -$signed({7'd0, n_m}) : $signed({7'd0, n_m});
        n_d      = 40'(r_p0) - n_t;
        n_ad     = n_d[39] ? -n_d : n_d;
        n_rem0   = 62'(r_amag) << SHIFT0;
        n_rem2   = {r_rem, 1'b0};
        n_tri    = 11'((12'(r_n) * 12'(7'(r_n) + 7'd1)) >> 1);
        n_qr     = {1'b0, r_q} + 42'(n_rem2 >= 62'(r_den));
        n_closed = (r_x == lp_pkg::ONE_Q) || (r_x == -lp_pkg::ONE_Q);
        n_state  = r_state;
        unique case (r_state)
            lp_pkg::SLP_IDLE:  if (i_start) n_state = lp_pkg::SLP_MUL;
            lp_pkg::SLP_MUL:   n_state = lp_pkg::SLP_PREP;
            lp_pkg::SLP_PREP:  n_state = lp_pkg::SLP_CHECK;
            lp_pkg::SLP_CHECK: begin
                if (n_closed || r_amag == '0 || n_rem0 >= 62'(r_den)) begin
                    n_state = lp_pkg::SLP_FIN;
                end else begin
                    n_state = lp_pkg::SLP_DIV;
                end
            end
            lp_pkg::SLP_DIV:   if (r_cnt == LAST) n_state = lp_pkg::SLP_ROUND;
            lp_pkg::SLP_ROUND: n_state = lp_pkg::SLP_FIN;
            lp_pkg::SLP_FIN:   n_state = lp_pkg::SLP_IDLE;
            default:           n_state = lp_pkg::SLP_IDLE;
        endcase
        o_done  = (r_state == lp_pkg::SLP_FIN);
        o_slope = r_sneg ? -$signed({1'b0, r_q[39:0]}) : $signed({1'b0, r_q[39:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lp_pkg::SLP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lp_pkg::SLP_IDLE: begin
                r_x  <= i_x;
                r_p0 <= i_p0;
                r_p1 <= i_p1;
                r_n  <= i_deg;
            end
            lp_pkg::SLP_MUL: begin
                r_prod <= 62'(31'(r_x[31] ? -r_x : r_x)) * 62'(31'(r_p1[31] ? -r_p1 : r_p1));
                r_pneg <= r_x[31] ^ r_p1[31];
                r_fa   <= 32'(33'(lp_pkg::ONE_Q) - 33'(r_x));
                r_fb   <= 32'(33'(lp_pkg::ONE_Q) + 33'(r_x));
                r_lim  <= 41'(n_tri) << lp_pkg::FRAC_BITS;
            end
            lp_pkg::SLP_PREP: begin
                r_dneg <= n_d[39];
                r_amag <= 38'(32'(n_ad)) * 38'(r_n);
                r_den  <= 61'(64'(r_fa) * 64'(r_fb));
            end
            lp_pkg::SLP_CHECK: begin
                r_cnt <= '0;
                r_rem <= 61'(n_rem0);
                if (n_closed) begin
                    // endpoints: sign flips at x = -1 for even degree
                    r_q    <= r_lim;
                    r_sneg <= r_x[31] & ~r_n[0];
                end else if (r_amag == '0) begin
                    r_q    <= '0;
                    r_sneg <= 1'b0;
                end else if (n_rem0 >= 62'(r_den)) begin
                    r_q    <= r_lim;
                    r_sneg <= r_dneg;
                end else begin
                    r_q    <= '0;
                    r_sneg <= r_dneg;
                end
            end
            lp_pkg::SLP_DIV: begin
                r_cnt <= r_cnt + 6'd1;
                if (n_rem2 >= 62'(r_den)) begin
                    r_rem <= 61'(n_rem2 - 62'(r_den));
                    r_q   <= {r_q[39:0], 1'b1};
                end else begin
                    r_rem <= 61'(n_rem2);
                    r_q   <= {r_q[39:0], 1'b0};
                end
            end
            lp_pkg::SLP_ROUND: begin
                r_q <= (n_qr > 42'(r_lim)) ? r_lim : 41'(n_qr);
            end
            lp_pkg::SLP_FIN: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end
endmodule
`default_nettype wire

/* dv/legendre_poly_value_and_slope_core_test.sv */
// testbench for the legendre value and slope core: directed corners, then random items
module legendre_poly_value_and_slope_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXDEG = lp_pkg::MAX_DEGREE_DEF;
    localparam longint ONE = 64'sd1 <<< lp_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [40:0] slope;
        logic [1:0]         status;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [5:0]         i_degree = '0;
    logic signed [31:0] i_point = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_value;
    logic signed [40:0] o_slope;
    logic [1:0]         o_status;

    t_result pending_results[$];
    int      err_count = 0;
    int      sent_count = 0;
    int      got_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    legendre_poly_value_and_slope_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_degree(i_degree), .i_point(i_point), .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_slope(o_slope), .o_status(o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // fixed-point product rounded half away from zero
    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        longint unsigned m;
        p = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << (lp_pkg::FRAC_BITS - 1));
        m = 64'(p >> lp_pkg::FRAC_BITS);
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_result legendre_eval(logic [5:0] n, logic signed [31:0] xin);
        t_result r;
        longint x, p0, p1, t, num, q, d, sl;
        longint unsigned lim, amag, den, uq, m;
        logic [127:0] wide;
        r = '0;
        x = xin;
        if (n < 1 || n > MAXDEG) begin
            r.status = lp_pkg::STAT_DEG;
            return r;
        end
        if (x < -ONE || x > ONE) begin
            r.status = lp_pkg::STAT_PT;
            return r;
        end
        p0 = ONE;
        p1 = x;
        for (int i = 2; i <= n; i++) begin
            t = qmul(x, p1);
            num = longint'(2 * i - 1) * t - longint'(i - 1) * p0;
            m = (mag(num) + i / 2) / i;
            q = num < 0 ? -longint'(m) : longint'(m);
            if (q > ONE) q = ONE;
            if (q < -ONE) q = -ONE;
            p0 = p1;
            p1 = q;
        end
        lim = 64'(n * (n + 1) / 2) * 64'(ONE);
        if (x == ONE || x == -ONE) begin
            sl = (x < 0 && n[0] == 1'b0) ? -longint'(lim) : longint'(lim);
        end else begin
            d = p0 - qmul(x, p1);
            amag = mag(d) * n;
            den = 64'(ONE - x) * 64'(ONE + x);
            if (amag == 0) uq = 0;
            else if (den == 0) uq = lim;
            else begin
                // round(amag * 2^60 / den) on the magnitude, then clamp
                wide = (128'(amag) << (2 * lp_pkg::FRAC_BITS)) / 128'(den);
                if (2 * ((128'(amag) << (2 * lp_pkg::FRAC_BITS)) % 128'(den)) >= 128'(den))
                    wide = wide + 1;
                uq = (wide > 128'(lim)) ? lim : 64'(wide);
            end
            sl = d < 0 ? -longint'(uq) : longint'(uq);
        end
        r.value = 32'(p1);
        r.slope = 41'(sl);
        r.status = lp_pkg::STAT_OK;
        return r;
    endfunction

    task automatic send_item(logic [5:0] n, logic signed [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_degree <= n;
        i_point <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(legendre_eval(n, x));
        sent_count++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transfer with the oldest pending expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            got_count++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                err_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_value !== e.value) begin
                    $error("value: expected %0d got %0d", e.value, o_value);
                    err_count++;
                end
                if (o_slope !== e.slope) begin
                    $error("slope: expected %0d got %0d", e.slope, o_slope);
                    err_count++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d got %0d", e.status, o_status);
                    err_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_point();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return $urandom();
        if (sel == 1)
            return 32'((($urandom_range(1) != 0) ? ONE : -ONE) + $signed($urandom_range(4) - 2));
        return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    function automatic logic [5:0] rand_degree();
        if ($urandom_range(19) == 0) return 6'($urandom_range(63));
        if ($urandom_range(3) == 0) return 6'($urandom_range(MAXDEG - 3, MAXDEG));
        return 6'($urandom_range(1, MAXDEG));
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [5:0] degs[6] = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33, 6'd63};
        logic signed [31:0] pts[9] = '{32'sh4000_0000, -32'sh4000_0000, 32'sh0,
            32'sh4000_0001, -32'sh4000_0001, 32'sh7fff_ffff, 32'sh8000_0000,
            32'sh3fff_ffff, -32'sh3fff_ffff};
        foreach (degs[i]) send_item(degs[i], pts[i % 9]);
        foreach (pts[i]) send_item(6'd7 + i[5:0], pts[i]);
        send_item(6'd32, 32'sh3fff_ffff);
        send_item(6'd31, -32'sh3fff_ffff);
        send_item(6'd2, 32'sh2000_0000);
        send_item(6'd3, -32'sh1234_5678);
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_item(rand_degree(), rand_point());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(100, 0, 0);
        test_random(100, 63, 0);
        test_random(100, 0, 63);
        test_random(100, 14, 14);
        $display("covered %0d items and %0d results: degree and point corners,",
            sent_count, got_count);
        $display("random items under sender gaps and receiver stalls");
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("legendre_poly_value_and_slope_core test passed");
        end else begin
            $display("legendre_poly_value_and_slope_core test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("legendre_poly_value_and_slope_core test failed");
        $finish;
    end
endmodule
